FILE: src/ulr_pkg.sv
`timescale 1ns / 1ps
package ulr_pkg;

	localparam logic [2:0] OFF_RXTX = 3'd0;
	localparam logic [2:0] OFF_IER  = 3'd1;
	localparam logic [2:0] OFF_IIR  = 3'd2;
	localparam logic [2:0] OFF_LCR  = 3'd3;
	localparam logic [2:0] OFF_MCR  = 3'd4;
	localparam logic [2:0] OFF_LSR  = 3'd5;
	localparam logic [2:0] OFF_MSR  = 3'd6;
	localparam logic [2:0] OFF_SCR  = 3'd7;

	localparam logic       ACT_READ  = 1'b0;
	localparam logic       ACT_WRITE = 1'b1;

	localparam logic [7:0] IIR_FIXED_BITS = 8'hC0;
	localparam logic [7:0] IER_READ_MASK  = 8'h0F;
	localparam logic [7:0] MSR_CONSTANT   = 8'hB3;

	localparam logic [7:0] IIR_LINE_STATUS = 8'h06;
	localparam logic [7:0] IIR_RX_DATA     = 8'h04;
	localparam logic [7:0] IIR_THR_EMPTY   = 8'h02;
	localparam logic [7:0] IIR_MODEM       = 8'h00;
	localparam logic [7:0] IIR_NONE        = 8'h01;

	localparam int TRIG_W = 4;

	typedef logic [TRIG_W-1:0] trig_t;

	function automatic trig_t trig_level(input logic [1:0] sel);
		trig_t lvl;
		unique case (sel)
			2'd0: lvl = trig_t'(1);
			2'd1: lvl = trig_t'(4);
			2'd2: lvl = trig_t'(8);
			default: lvl = trig_t'(14);
		endcase
		return lvl;
	endfunction

endpackage

FILE: src/uart_16550_loopback_registers_top.sv
`timescale 1ns / 1ps
// channel  dir  tdata                                   tuser
// s_*      in   [2:0] reg_offset, [10:3] write_data     [0] action (0 read, 1 write)
// m_*      out  [7:0] read_data, [9:8] irq_events       -
//
// One register access per cycle while m_tready does not stall: each word is
// captured in the input register and its result then in the output register.
// The state update and the FIFO read-ahead both close in that single pass.
// arst_n clears flags, pointers and control state, not data or FIFO memory.
// A stall on m_tready holds the output and the input register; s_tready drops
// only when both are full.
module uart_16550_loopback_registers_top
	import ulr_pkg::*;
#(
	parameter int FIFO_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [2:0] reg_offset, [10:3] write_data
	input  logic [0:0]  s_tuser,   // [0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [7:0] read_data, [9:8] irq_events
);

	localparam int AW   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CW   = $clog2(FIFO_DEPTH + 1);
	localparam int CMPW = CW + TRIG_W;

	logic          valid_s1;
	logic          action_s1;
	logic [2:0]    offset_s1;
	logic [7:0]    wdata_s1;

	logic          out_valid_q;
	logic [7:0]    rdata_q;
	logic [1:0]    irq_q;

	logic [AW-1:0] head_q, tail_q;
	logic [CW-1:0] count_q;
	logic [7:0]    ier_q, lcr_q, mcr_q, scr_q;
	logic          ovr_q;
	logic [15:0]   div_q;
	logic          lim1_q;
	trig_t         trig_q;

	logic [7:0]    mem [FIFO_DEPTH];
	logic [7:0]    rd_q;

	logic          advance, fire;
	logic [AW-1:0] head_d, tail_d;
	logic [CW-1:0] count_d, count_inc, count_dec;
	logic [7:0]    ier_d, lcr_d, mcr_d, scr_d;
	logic          ovr_d;
	logic [15:0]   div_d;
	logic          lim1_d;
	trig_t         trig_d;
	logic          mem_we;
	logic [7:0]    rdata_d, iir_d;
	logic          ev_a, ev_b;
	logic          dlab, empty, can_push;
	logic          trig_hit, trig_hit_inc;

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		return (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign advance  = !out_valid_q || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	assign dlab      = lcr_q[7];
	assign empty     = (count_q == '0);
	assign count_inc = count_q + 1'b1;
	assign count_dec = count_q - 1'b1;
	assign can_push  = lim1_q ? empty : (count_q != CW'(FIFO_DEPTH));
	assign trig_hit  = ({{TRIG_W{1'b0}}, count_q} == {{CW{1'b0}}, trig_q});
	assign trig_hit_inc = ({{TRIG_W{1'b0}}, count_inc} == CMPW'({{CW{1'b0}}, trig_q}));

	always_comb begin
		priority if (ier_q[2] && ovr_q) begin
			iir_d = IIR_LINE_STATUS;
		end else if (ier_q[0] && trig_hit) begin
			iir_d = IIR_RX_DATA;
		end else if (ier_q[1] && empty) begin
			iir_d = IIR_THR_EMPTY;
		end else if (ier_q[3] && (mcr_q[1:0] != 2'b00)) begin
			iir_d = IIR_MODEM;
		end else begin
			iir_d = IIR_NONE;
		end
	end

	always_comb begin
		head_d  = head_q;
		tail_d  = tail_q;
		count_d = count_q;
		ier_d   = ier_q;
		lcr_d   = lcr_q;
		mcr_d   = mcr_q;
		scr_d   = scr_q;
		ovr_d   = ovr_q;
		div_d   = div_q;
		lim1_d  = lim1_q;
		trig_d  = trig_q;
		mem_we  = 1'b0;
		rdata_d = '0;
		ev_a    = 1'b0;
		ev_b    = 1'b0;
		if (fire) begin
			if (action_s1 == ACT_WRITE) begin
				unique case (offset_s1)
					OFF_RXTX: begin
						if (dlab) begin
							div_d = div_q | {8'h00, wdata_s1};
						end else if (can_push) begin
							mem_we  = 1'b1;
							head_d  = ptr_next(head_q);
							count_d = count_inc;
							ovr_d   = 1'b0;
							ev_a    = ier_q[0] && trig_hit_inc;
						end else begin
							ovr_d = 1'b1;
							ev_a  = ier_q[2];
						end
					end
					OFF_IER: begin
						if (dlab) begin
							div_d = div_q | {wdata_s1, 8'h00};
						end else begin
							ier_d = wdata_s1;
							ev_a  = wdata_s1[1] && empty;
						end
					end
					OFF_IIR: begin
						if (wdata_s1[2:1] != 2'b00) begin
							count_d = '0;
							head_d  = '0;
							tail_d  = '0;
						end
						if (wdata_s1[0]) begin
							lim1_d = 1'b0;
							trig_d = trig_level(wdata_s1[7:6]);
						end else begin
							lim1_d = 1'b1;
							trig_d = trig_t'(1);
						end
					end
					OFF_LCR: begin
						lcr_d = wdata_s1;
						if (wdata_s1[7]) begin
							div_d = '0;
						end
					end
					OFF_MCR: begin
						mcr_d = wdata_s1;
						ev_a  = ier_q[3] && wdata_s1[3];
						ev_b  = ier_q[3] && (wdata_s1[1:0] != 2'b00);
					end
					OFF_LSR, OFF_MSR: begin
					end
					default: begin
						scr_d = wdata_s1;
					end
				endcase
			end else begin
				unique case (offset_s1)
					OFF_RXTX: begin
						if (dlab) begin
							rdata_d = div_q[7:0];
						end else if (!empty) begin
							rdata_d = rd_q;
							count_d = count_dec;
							tail_d  = ptr_next(tail_q);
							ev_a    = ier_q[1] && (count_dec == '0);
						end else begin
							ev_a = ier_q[1];
						end
					end
					OFF_IER: rdata_d = dlab ? div_q[15:8] : (ier_q & IER_READ_MASK);
					OFF_IIR: rdata_d = iir_d | IIR_FIXED_BITS;
					OFF_LCR: rdata_d = lcr_q;
					OFF_MCR: rdata_d = mcr_q;
					OFF_LSR: rdata_d = {1'b0, empty, empty, 3'b000, ovr_q, !empty};
					OFF_MSR: rdata_d = MSR_CONSTANT;
					default: rdata_d = scr_q;
				endcase
			end
		end
	end

	// read-ahead of the oldest byte, bypassing a write to the same entry
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[head_q] <= wdata_s1;
		end
		rd_q <= (mem_we && (head_q == tail_d)) ? wdata_s1 : mem[tail_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			ier_q       <= '0;
			lcr_q       <= '0;
			mcr_q       <= '0;
			scr_q       <= '0;
			ovr_q       <= 1'b0;
			div_q       <= '0;
			lim1_q      <= 1'b0;
			trig_q      <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			ier_q   <= ier_d;
			lcr_q   <= lcr_d;
			mcr_q   <= mcr_d;
			scr_q   <= scr_d;
			ovr_q   <= ovr_d;
			div_q   <= div_d;
			lim1_q  <= lim1_d;
			trig_q  <= trig_d;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1 <= s_tuser[0];
			offset_s1 <= s_tdata[2:0];
			wdata_s1  <= s_tdata[10:3];
		end
		if (fire) begin
			rdata_q <= rdata_d;
			irq_q   <= 2'({1'b0, ev_a} + {1'b0, ev_b});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b000000, irq_q, rdata_q};

endmodule

FILE: src/ulr_checker.sv
`timescale 1ns / 1ps
module ulr_checker
	import ulr_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [15:0] s_tdata,
	input logic [0:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	a_idle_in_reset: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("output valid during reset");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output word changed");

	a_irq_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[9:8] != 2'b11) && (m_tdata[15:10] == 6'b000000))
		else $error("bad irq count or padding");

	a_ready_only_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input blocked without output stall");

	a_input_held: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
		else $error("waiting input word changed");

endmodule

bind uart_16550_loopback_registers_top ulr_checker u_ulr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
